/* rtl/core/ebbf_pkg.sv */
// ----------------------------------------------------------------------------
// ebbf_pkg
// Shared types, constants and exp tables of the energy buffer bilateral filter.
// ----------------------------------------------------------------------------
package ebbf_pkg;

    // operation codes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_BLUR   = 3'd4;
    localparam logic [2:0] OP_COMMIT = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BLUR_RADIUS  = 3'd2;
    localparam logic [2:0] REG_SPATIAL_INV  = 3'd3;
    localparam logic [2:0] REG_RANGE_INV    = 3'd4;

    // exp argument cap, 12.0 in Q16.16
    localparam logic [19:0] ARG_CAP = 20'd786432;

    // one neighbor request into the weight pipeline
    typedef struct packed {
        logic        vld;
        logic [31:0] nb;
        logic [19:0] as_arg;
    } t_nbr;

    // round(65536 * e^-n), zero from n = 12 on
    function automatic logic [16:0] f_exp_int(input logic [4:0] n);
        logic [16:0] v;
        unique case (n)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd24109;
            5'd2:    v = 17'd8869;
            5'd3:    v = 17'd3263;
            5'd4:    v = 17'd1200;
            5'd5:    v = 17'd442;
            5'd6:    v = 17'd162;
            5'd7:    v = 17'd60;
            5'd8:    v = 17'd22;
            5'd9:    v = 17'd8;
            5'd10:   v = 17'd3;
            5'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // round(65536 * e^-(k/16)), k = 0..16
    function automatic logic [16:0] f_exp_frac(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            default: v = 17'd24109;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/energy_buffer_bilateral_filter_top.sv */
// ----------------------------------------------------------------------------
// energy_buffer_bilateral_filter_top
// Two-bank energy image store with per-pixel bilateral blur.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the block sweeps both banks to
// zero before it takes the first request. An in-frame read, and an in-frame
// add of a nonzero value, go through a read state for the registered memory
// read; write and commit do not. Clear sweeps the whole active bank, one entry
// per cycle. A blur reads its (2r+1)^2 window one neighbor per cycle through
// the memory read port, drains a six-stage weight pipeline and then runs a
// one-bit-per-cycle divider. Results wait in an output register.
// ----------------------------------------------------------------------------
module energy_buffer_bilateral_filter_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_pos_x,
    input  logic [5:0]  i_pos_y,
    input  logic [31:0] i_energy_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_energy_out,
    output logic        o_in_range
);
    import ebbf_pkg::*;

    localparam int AREA  = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH = 2 * AREA;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS + 1) + 1;
    localparam int TAPS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CW    = $clog2(TAPS + 1);
    localparam int WS_W  = 17 + CW;
    localparam int ACC_W = 49 + CW;
    localparam int DW    = ACC_W + 1;

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_CLR   = 4'd3;
    localparam logic [3:0] ST_BLUR  = 4'd4;
    localparam logic [3:0] ST_DRAIN = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    function automatic logic [AW-1:0] f_addr(input logic bank, input logic [6:0] xx,
                                             input logic [6:0] yy);
        return (bank ? AW'(AREA) : AW'(0)) + AW'(yy) * AW'(MAX_WIDTH) + AW'(xx);
    endfunction

    // configuration registers
    logic [6:0]  r_fw, r_fh;
    logic [2:0]  r_br;
    logic [23:0] r_siv, r_riv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= 7'd64;
            r_fh  <= 7'd64;
            r_br  <= 3'd1;
            r_siv <= 24'd32768;
            r_riv <= 24'd32768;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_fw  <= i_cfg_wdata[6:0];
                REG_FRAME_HEIGHT: r_fh  <= i_cfg_wdata[6:0];
                REG_BLUR_RADIUS:  r_br  <= i_cfg_wdata[2:0];
                REG_SPATIAL_INV:  r_siv <= i_cfg_wdata;
                REG_RANGE_INV:    r_riv <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped frame size and radius
    logic [6:0]          w, h;
    logic [2:0]          rad_u;
    logic signed [RW-1:0] rad;
    assign w = (r_fw == 7'd0) ? 7'd1 :
               (32'(r_fw) > MAX_WIDTH) ? 7'(MAX_WIDTH) : r_fw;
    assign h = (r_fh == 7'd0) ? 7'd1 :
               (32'(r_fh) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : r_fh;
    assign rad_u = (r_br == 3'd0) ? 3'd1 :
                   (32'(r_br) > MAX_RADIUS) ? 3'(MAX_RADIUS) : r_br;
    assign rad = RW'($signed({1'b0, rad_u}));

    // control and request registers
    logic [3:0]           r_state;
    logic [2:0]           r_op;
    logic [5:0]           r_x, r_y;
    logic [31:0]          r_v;
    logic                 r_bank;
    logic [31:0]          r_center;
    logic [31:0]          r_res;
    logic                 r_flag;
    logic [AW-1:0]        r_sweep;
    logic signed [RW-1:0] r_kx, r_ky;
    logic                 r_iss_vld;
    logic [19:0]          r_iss_as;
    logic                 r_out_vld;
    logic [31:0]          r_out_data;
    logic                 r_out_flag;

    logic [31:0] rdata;
    logic        w_busy;
    logic [ACC_W-1:0] w_acc;
    logic [WS_W-1:0]  w_wsum;
    logic        div_done;
    logic [DW-1:0] div_q;

    // handshakes
    logic in_acc, in_frame;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_frame   = ({1'b0, i_pos_x} < w) && ({1'b0, i_pos_y} < h);

    // window coordinates, clamped to the frame edge
    logic signed [8:0] sx, sy;
    logic [6:0]        cx, cy;
    assign sx = $signed({3'd0, r_x}) + 9'(r_kx);
    assign sy = $signed({3'd0, r_y}) + 9'(r_ky);
    assign cx = sx[8] ? 7'd0 : (sx[7:0] >= {1'b0, w}) ? w - 7'd1 : sx[6:0];
    assign cy = sy[8] ? 7'd0 : (sy[7:0] >= {1'b0, h}) ? h - 7'd1 : sy[6:0];

    // spatial argument for the current tap
    logic signed [2*RW-1:0] kx2, ky2;
    logic [2*RW:0]          ds;
    logic [2*RW+24:0]       as_full;
    logic [19:0]            as_cap;
    assign kx2     = r_kx * r_kx;
    assign ky2     = r_ky * r_ky;
    assign ds      = {1'b0, kx2} + {1'b0, ky2};
    assign as_full = (2*RW+25)'(ds) * (2*RW+25)'(r_siv);
    assign as_cap  = (as_full > (2*RW+25)'(ARG_CAP)) ? ARG_CAP : as_full[19:0];

    // memory read address
    logic [AW-1:0] raddr;
    assign raddr = (r_state == ST_BLUR) ? f_addr(r_bank, cx, cy)
                                        : f_addr(r_bank, {1'b0, i_pos_x}, {1'b0, i_pos_y});

    // saturating add
    logic [32:0] sum33;
    assign sum33 = {1'b0, rdata} + {1'b0, r_v};

    // blur finish
    logic          wsum_zero;
    logic [DW-1:0] dividend;
    assign wsum_zero = (w_wsum == '0);
    assign dividend  = {1'b0, w_acc} + DW'(w_wsum >> 1);

    // memory write port
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    always_comb begin
        we    = 1'b0;
        waddr = f_addr(~r_bank, {1'b0, r_x}, {1'b0, r_y});
        wdata = r_center;
        unique case (r_state)
            ST_INIT: begin
                we    = 1'b1;
                waddr = r_sweep;
                wdata = '0;
            end
            ST_CLR: begin
                we    = 1'b1;
                waddr = (r_bank ? AW'(AREA) : AW'(0)) + r_sweep;
                wdata = '0;
            end
            ST_IDLE: begin
                we    = in_acc && (i_operation == OP_WRITE) && in_frame;
                waddr = f_addr(r_bank, {1'b0, i_pos_x}, {1'b0, i_pos_y});
                wdata = i_energy_in;
            end
            ST_RD: begin
                we    = (r_op == OP_ADD);
                waddr = f_addr(r_bank, {1'b0, r_x}, {1'b0, r_y});
                wdata = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
            end
            ST_DRAIN: begin
                we    = !r_iss_vld && !w_busy && wsum_zero;
                wdata = r_center;
            end
            ST_DIV: begin
                we    = div_done;
                wdata = div_q[31:0];
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_bank    <= 1'b0;
            r_sweep   <= '0;
            r_iss_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_iss_vld <= 1'b0;
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_operation;
                        r_x     <= i_pos_x;
                        r_y     <= i_pos_y;
                        r_v     <= i_energy_in;
                        r_res   <= '0;
                        r_flag  <= 1'b0;
                        r_state <= ST_DONE;
                        unique case (i_operation)
                            OP_WRITE: r_flag <= in_frame;
                            OP_ADD: begin
                                r_flag <= in_frame;
                                if (in_frame && i_energy_in != 32'd0) begin
                                    r_state <= ST_RD;
                                end
                            end
                            OP_READ, OP_BLUR: begin
                                r_flag <= in_frame;
                                if (in_frame) begin
                                    r_state <= ST_RD;
                                end
                            end
                            OP_CLEAR: begin
                                r_sweep <= '0;
                                r_state <= ST_CLR;
                            end
                            OP_COMMIT: r_bank <= ~r_bank;
                            default: ;
                        endcase
                    end
                end
                ST_RD: begin
                    r_state <= ST_DONE;
                    if (r_op == OP_READ) begin
                        r_res <= rdata;
                    end else if (r_op == OP_BLUR) begin
                        r_center <= rdata;
                        r_kx     <= -rad;
                        r_ky     <= -rad;
                        r_state  <= ST_BLUR;
                    end
                end
                ST_CLR: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == AW'(AREA - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_BLUR: begin
                    // issue one neighbor read per cycle
                    r_iss_vld <= 1'b1;
                    r_iss_as  <= as_cap;
                    if (r_kx == rad) begin
                        r_kx <= -rad;
                        if (r_ky == rad) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_ky <= r_ky + RW'(1);
                        end
                    end else begin
                        r_kx <= r_kx + RW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_iss_vld && !w_busy) begin
                        if (wsum_zero) begin
                            r_res   <= r_center;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_res   <= div_q[31:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_vld || i_out_ready)) begin
            r_out_data <= r_res;
            r_out_flag <= r_flag;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_energy_out = r_out_data;
    assign o_in_range   = r_out_flag;

    // neighbor request into the weight pipeline
    t_nbr nbr;
    assign nbr.vld    = r_iss_vld;
    assign nbr.nb     = rdata;
    assign nbr.as_arg = r_iss_as;

    logic div_start;
    assign div_start = (r_state == ST_DRAIN) && !r_iss_vld && !w_busy && !wsum_zero;

    ebbf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ebbf_weight #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_weight (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       ((r_state == ST_RD) && (r_op == OP_BLUR)),
        .i_nbr       (nbr),
        .i_center    (r_center),
        .i_range_inv (r_riv),
        .o_busy      (w_busy),
        .o_acc       (w_acc),
        .o_wsum      (w_wsum)
    );

    ebbf_div #(
        .DW (DW),
        .VW (WS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (w_wsum),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

endmodule

/* rtl/core/ebbf_store.sv */
// ----------------------------------------------------------------------------
// ebbf_store
// Two-bank energy memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ebbf_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ebbf_weight.sv */
// ----------------------------------------------------------------------------
// ebbf_weight
// Per-neighbor range/spatial weight pipeline and weighted-sum accumulator.
// ----------------------------------------------------------------------------
module ebbf_weight #(
    parameter int    MAX_RADIUS = 4,
    localparam int   TAPS       = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1),
    localparam int   CW         = $clog2(TAPS + 1),
    localparam int   WS_W       = 17 + CW,
    localparam int   ACC_W      = 49 + CW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  ebbf_pkg::t_nbr       i_nbr,
    input  logic [31:0]          i_center,
    input  logic [23:0]          i_range_inv,
    output logic                 o_busy,
    output logic [ACC_W-1:0]     o_acc,
    output logic [WS_W-1:0]      o_wsum
);
    import ebbf_pkg::*;

    logic [6:1]  r_v;
    logic [31:0] r_nb1, r_nb2, r_nb3, r_nb4, r_nb5, r_nb6;
    logic [19:0] r_as1, r_as2, r_as3;
    logic [31:0] r_d;
    logic [47:0] r_sq;
    logic [19:0] r_ar;
    logic [16:0] r_ei4, r_ei5;
    logic [16:0] r_a;
    logic [11:0] r_diff, r_r;
    logic        r_z4, r_z5;
    logic [16:0] r_frac;
    logic [16:0] r_wgt;
    logic [ACC_W-1:0] r_acc;
    logic [WS_W-1:0]  r_wsum;

    // stage 2: squared difference
    logic [63:0] dd;
    assign dd = {32'd0, r_d} * {32'd0, r_d};

    // stage 3: range argument with saturation
    logic [59:0] rprod;
    logic [19:0] ar;
    assign rprod = {24'd0, r_sq[35:0]} * {36'd0, i_range_inv};
    always_comb begin
        if (i_range_inv == 24'd0) begin
            ar = 20'd0;
        end else if (r_sq[47:36] != 12'd0) begin
            ar = ARG_CAP;
        end else if (rprod[59:16] > {24'd0, ARG_CAP}) begin
            ar = ARG_CAP;
        end else begin
            ar = rprod[35:16];
        end
    end

    // stage 4: split argument, table lookup
    logic [20:0] arg;
    logic [16:0] ta, tb;
    assign arg = {1'b0, r_as3} + {1'b0, r_ar};
    assign ta  = f_exp_frac({1'b0, arg[15:12]});
    assign tb  = f_exp_frac({1'b0, arg[15:12]} + 5'd1);

    // stage 5: linear interpolation
    logic [23:0] ip;
    assign ip = {12'd0, r_diff} * {12'd0, r_r};

    // stage 6: integer part times fraction, rounded
    logic [33:0] ep;
    assign ep = ({17'd0, r_ei5} * {17'd0, r_frac}) + 34'd32768;

    // stage 7 product
    logic [48:0] wp;
    assign wp = {17'd0, r_nb6} * {32'd0, r_wgt};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], i_nbr.vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_nb1  <= i_nbr.nb;
        r_as1  <= i_nbr.as_arg;
        r_d    <= (i_nbr.nb >= i_center) ? i_nbr.nb - i_center : i_center - i_nbr.nb;
        r_nb2  <= r_nb1;
        r_as2  <= r_as1;
        r_sq   <= dd[63:16];
        r_nb3  <= r_nb2;
        r_as3  <= r_as2;
        r_ar   <= ar;
        r_nb4  <= r_nb3;
        r_ei4  <= f_exp_int(arg[20:16]);
        r_z4   <= (arg[20:16] >= 5'd12);
        r_a    <= ta;
        r_diff <= 12'(ta - tb);
        r_r    <= arg[11:0];
        r_nb5  <= r_nb4;
        r_ei5  <= r_ei4;
        r_z5   <= r_z4;
        r_frac <= r_a - {5'd0, ip[23:12]};
        r_nb6  <= r_nb5;
        r_wgt  <= r_z5 ? 17'd0 : ep[32:16];
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_acc  <= '0;
            r_wsum <= '0;
        end else if (r_v[6]) begin
            r_acc  <= r_acc + ACC_W'(wp);
            r_wsum <= r_wsum + WS_W'(r_wgt);
        end
    end

    assign o_busy = |r_v;
    assign o_acc  = r_acc;
    assign o_wsum = r_wsum;

endmodule

/* rtl/core/ebbf_div.sv */
// ----------------------------------------------------------------------------
// ebbf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ebbf_div #(
    parameter int DW = 58,
    parameter int VW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNW = $clog2(DW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_q;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_dv;

    // one restoring step
    logic [VW:0] rem_sh, diff;
    assign rem_sh = {r_rem, r_q[DW-1]};
    assign diff   = rem_sh - {1'b0, r_dv};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNW'(1);
                if (r_cnt == CNW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            if (!diff[VW]) begin
                r_rem <= diff[VW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[VW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
